>>> src/bwm_pkg.sv
// ============================================================================
// Battery window monitor package
// Shared state type, register indexes and arithmetic constants.
// ============================================================================
package bwm_pkg;

    // Sequencer states of the monitor.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_WALK,
        ST_AVG_DIV,
        ST_PCT_LOAD,
        ST_PCT_DIV,
        ST_DONE
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPREAD_LIMIT = 3'd0;
    localparam logic [2:0] CFG_PRESENT_MIN  = 3'd1;
    localparam logic [2:0] CFG_PRESENT_MAX  = 3'd2;
    localparam logic [2:0] CFG_EMPTY        = 3'd3;
    localparam logic [2:0] CFG_FULL         = 3'd4;

    // Register reset values.
    localparam logic [11:0] RST_SPREAD_LIMIT = 12'd200;
    localparam logic [12:0] RST_PRESENT_MIN  = 13'd2700;
    localparam logic [12:0] RST_PRESENT_MAX  = 13'd4300;
    localparam logic [12:0] RST_EMPTY        = 13'd3300;
    localparam logic [12:0] RST_FULL         = 13'd4200;

    // Pin full scale in millivolts; the code full scale is 4095.
    localparam logic [11:0] PIN_FS_MV = 12'd3300;

    // Battery divider ratio and percent scale.
    localparam logic [6:0] BATT_NUM    = 7'd115;
    localparam logic [6:0] BATT_DEN    = 7'd82;
    localparam logic [6:0] PCT_FULL    = 7'd100;

    // The ratio 115/82 as ceil(115 * 2^20 / 82); the product shifted right by
    // 20 gives the truncated quotient for every 12-bit mean.
    localparam logic [20:0] BATT_RECIP = 21'd1470564;
    localparam int          BATT_SHIFT = 20;

    // Serial divider: dividend and divisor widths, step counter width.
    localparam int DIV_W     = 20;
    localparam int DVS_W     = 13;
    localparam int DIV_CNT_W = 5;

endpackage

>>> src/battery_window_monitor.sv
// ============================================================================
// Battery window monitor
// Scales converter codes to pin millivolts, keeps them in a circular window
// memory and reports mean, spread, battery voltage, percent and presence.
// ============================================================================
//
//  Channel    Direction  Signals                          Content
//  s_axis     in         tvalid/tready/tdata[15:0]        one converter code
//  m_axis     out        tvalid/tready/tdata[47:0]/tuser  one result per code
//  cfg        in         i_cfg_valid/o_cfg_ready/index    register write
//
//  The walk reads one window entry per cycle through the single memory read
//  port, and a bit-serial divider of 20 steps runs twice, for the mean and
//  the percent; the battery scaling is a reciprocal multiplication.
//  Reset clears the write position, fill count, registers and handshakes; the
//  window memory needs no clearing since only written entries are read.
//  A new code is taken while a result still waits on m_axis; the result of
//  that code waits in the done state until the output register is free.
//  Configuration writes are always taken.
//
module battery_window_monitor #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_code, [15:12] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [11:0] pin_avg_mv, [24:12] battery_mv,
                                        // [31:25] percent, [43:32] spread_mv,
                                        // [47:44] zero
    output logic        m_axis_tuser,   // [0] present

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 12 + CW;
    localparam int HALF  = WINDOW_DEPTH / 2;
    localparam int DVS_W = bwm_pkg::DVS_W;

    // Configuration registers.
    logic [11:0] r_cfg_spread;
    logic [12:0] r_cfg_pmin;
    logic [12:0] r_cfg_pmax;
    logic [12:0] r_cfg_empty;
    logic [12:0] r_cfg_full;

    // Sequencer.
    bwm_pkg::t_state r_state;
    bwm_pkg::t_state n_state;

    // Window memory and its pointers.
    logic [11:0]   mem_window [WINDOW_DEPTH];
    logic [AW-1:0] r_wr_pos;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_rd_idx;
    logic          r_rd_pend;
    logic [11:0]   r_rd_data;

    // Working registers.
    logic [23:0]    r_prod;
    logic [11:0]    r_mv;
    logic [SUM_W-1:0] r_sum;
    logic [11:0]    r_lo;
    logic [11:0]    r_hi;
    logic [11:0]    r_avg;
    logic [11:0]    r_spread;
    logic [12:0]    r_batt;
    logic [6:0]     r_pct;
    logic           r_present;

    // Serial divider.
    logic [DVS_W-1:0]           r_div_rem;
    logic [bwm_pkg::DIV_W-1:0]  r_div_quo;
    logic [DVS_W-1:0]           r_div_den;
    logic [bwm_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DVS_W:0]             div_shift;
    logic                       div_ge;
    logic                       div_done;

    // Output register.
    logic        r_out_valid;
    logic [11:0] r_out_avg;
    logic [12:0] r_out_batt;
    logic [6:0]  r_out_pct;
    logic        r_out_present;
    logic [11:0] r_out_spread;

    // Decoded controls.
    logic          s_accept;
    logic          m_accept;
    logic          rd_en;
    logic          out_load;
    logic [24:0]   scale_sum;
    logic [32:0]   batt_prod;
    logic [6:0]    pct_sel;
    logic          present_sel;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = r_out_valid && m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_spread <= bwm_pkg::RST_SPREAD_LIMIT;
            r_cfg_pmin   <= bwm_pkg::RST_PRESENT_MIN;
            r_cfg_pmax   <= bwm_pkg::RST_PRESENT_MAX;
            r_cfg_empty  <= bwm_pkg::RST_EMPTY;
            r_cfg_full   <= bwm_pkg::RST_FULL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bwm_pkg::CFG_SPREAD_LIMIT: r_cfg_spread <= i_cfg_data[11:0];
                bwm_pkg::CFG_PRESENT_MIN:  r_cfg_pmin   <= i_cfg_data;
                bwm_pkg::CFG_PRESENT_MAX:  r_cfg_pmax   <= i_cfg_data;
                bwm_pkg::CFG_EMPTY:        r_cfg_empty  <= i_cfg_data;
                bwm_pkg::CFG_FULL:         r_cfg_full   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bwm_pkg::ST_IDLE:     if (s_axis_tvalid) n_state = bwm_pkg::ST_SCALE;
            bwm_pkg::ST_SCALE:    n_state = bwm_pkg::ST_WRITE;
            bwm_pkg::ST_WRITE:    n_state = bwm_pkg::ST_WALK;
            bwm_pkg::ST_WALK: begin
                if (r_rd_idx == r_fill && !r_rd_pend) n_state = bwm_pkg::ST_AVG_DIV;
            end
            bwm_pkg::ST_AVG_DIV:  if (div_done) n_state = bwm_pkg::ST_PCT_LOAD;
            bwm_pkg::ST_PCT_LOAD: n_state = bwm_pkg::ST_PCT_DIV;
            bwm_pkg::ST_PCT_DIV:  if (div_done) n_state = bwm_pkg::ST_DONE;
            bwm_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = bwm_pkg::ST_IDLE;
            end
            default:              n_state = bwm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            bwm_pkg::ST_IDLE: s_axis_tready = 1'b1;
            bwm_pkg::ST_WALK: rd_en = (r_rd_idx != r_fill);
            bwm_pkg::ST_DONE: out_load = !r_out_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Window memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == bwm_pkg::ST_WRITE) begin
            mem_window[r_wr_pos] <= r_mv;
        end
        if (rd_en) begin
            r_rd_data <= mem_window[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos  <= '0;
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
            if (r_state == bwm_pkg::ST_WRITE) begin
                r_rd_idx <= '0;
                if (r_wr_pos == AW'(WINDOW_DEPTH - 1)) begin
                    r_wr_pos <= '0;
                end else begin
                    r_wr_pos <= r_wr_pos + AW'(1);
                end
                if (r_fill != CW'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + CW'(1);
                end
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    // Division by 4095 = 2^12 - 1 of a product below 2^24, exact.
    assign scale_sum = {1'b0, r_prod} + 25'(r_prod[23:12]) + 25'd1;

    // Battery millivolts from the finished mean quotient.
    assign batt_prod = {21'd0, r_div_quo[11:0]} * {12'd0, bwm_pkg::BATT_RECIP};

    assign div_shift = {r_div_rem, r_div_quo[bwm_pkg::DIV_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_div_den};
    assign div_done  = (r_div_cnt == '0);

    always_comb begin
        if (r_batt <= r_cfg_empty) begin
            pct_sel = 7'd0;
        end else if (r_batt >= r_cfg_full) begin
            pct_sel = bwm_pkg::PCT_FULL;
        end else begin
            pct_sel = r_div_quo[6:0];
        end
    end

    assign present_sel = (r_fill >= CW'(HALF)) && (r_spread <= r_cfg_spread)
                      && (r_batt >= r_cfg_pmin) && (r_batt <= r_cfg_pmax);

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_prod <= {12'd0, s_axis_tdata[11:0]} * {12'd0, bwm_pkg::PIN_FS_MV};
        end
        case (r_state)
            bwm_pkg::ST_SCALE: r_mv <= scale_sum[23:12];
            bwm_pkg::ST_WRITE: begin
                r_sum <= '0;
                r_lo  <= '1;
                r_hi  <= '0;
            end
            bwm_pkg::ST_WALK: begin
                if (r_rd_pend) begin
                    r_sum <= r_sum + SUM_W'(r_rd_data);
                    if (r_rd_data < r_lo) r_lo <= r_rd_data;
                    if (r_rd_data > r_hi) r_hi <= r_rd_data;
                end
                // Load the divider for the mean as the walk ends.
                r_div_rem <= '0;
                r_div_quo <= bwm_pkg::DIV_W'(r_sum);
                r_div_den <= DVS_W'(r_fill);
                r_div_cnt <= bwm_pkg::DIV_CNT_W'(bwm_pkg::DIV_W);
            end
            bwm_pkg::ST_PCT_LOAD: begin
                // The percent quotient is only used when the battery
                // voltage lies strictly between the thresholds.
                r_div_rem <= '0;
                r_div_quo <= bwm_pkg::DIV_W'(r_batt - r_cfg_empty)
                           * bwm_pkg::DIV_W'(bwm_pkg::PCT_FULL);
                r_div_den <= r_cfg_full - r_cfg_empty;
                r_div_cnt <= bwm_pkg::DIV_CNT_W'(bwm_pkg::DIV_W);
            end
            bwm_pkg::ST_AVG_DIV, bwm_pkg::ST_PCT_DIV: begin
                if (!div_done) begin
                    r_div_cnt <= r_div_cnt - bwm_pkg::DIV_CNT_W'(1);
                    if (div_ge) begin
                        r_div_rem <= DVS_W'(div_shift - {1'b0, r_div_den});
                        r_div_quo <= {r_div_quo[bwm_pkg::DIV_W-2:0], 1'b1};
                    end else begin
                        r_div_rem <= div_shift[DVS_W-1:0];
                        r_div_quo <= {r_div_quo[bwm_pkg::DIV_W-2:0], 1'b0};
                    end
                end else if (r_state == bwm_pkg::ST_AVG_DIV) begin
                    r_avg    <= r_div_quo[11:0];
                    r_spread <= r_hi - r_lo;
                    r_batt   <= batt_prod[bwm_pkg::BATT_SHIFT +: 13];
                end else begin
                    r_pct     <= pct_sel;
                    r_present <= present_sel;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg     <= r_avg;
            r_out_batt    <= r_batt;
            r_out_pct     <= r_pct;
            r_out_present <= r_present;
            r_out_spread  <= r_spread;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_spread, r_out_pct, r_out_batt, r_out_avg};
    assign m_axis_tuser  = r_out_present;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("fill count above window depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwm_pkg::ST_WALK) |-> (r_rd_idx <= r_fill))
        else $error("window walk past fill count");

    a_mean_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwm_pkg::ST_AVG_DIV) |-> (r_div_den != '0))
        else $error("mean divider started with zero count");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == bwm_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule

>>> tb/sv/tb_battery_window_monitor.sv
// ============================================================================
// Battery window monitor testbench
// Streams converter codes into the monitor under random bursts and output
// stalls, predicts every result from its own copy of the sample window and
// the registers, and compares each received result field by field.
// ============================================================================
module tb_battery_window_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WINDOW_DEPTH = 32;
    localparam int unsigned CODE_FS      = 4095;
    localparam logic [2:0]  CFG_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CFG_UNUSED_HI = 3'd7;
    localparam int          NUM_PHASES   = 12;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          HOLD_CYCLES  = 800;
    localparam int          TAIL_CYCLES  = 200;
    localparam int          LIMIT_CYCLES = 2_000_000;
    localparam int          MAX_REPORTS  = 40;

    typedef struct packed {
        logic [11:0] avg_mv;
        logic [12:0] batt_mv;
        logic [6:0]  pct;
        logic        present;
        logic [11:0] spread_mv;
    } t_reading;

    // Keeps a shadow of the window and registers and the readings still owed.
    class battery_scoreboard;
        logic [11:0]  window [WINDOW_DEPTH];
        int unsigned  wr_pos;
        int unsigned  fill;
        logic [11:0]  spread_limit;
        logic [12:0]  present_min;
        logic [12:0]  present_max;
        logic [12:0]  empty_mv;
        logic [12:0]  full_mv;
        t_reading     reading_q [$];
        int unsigned  errors;

        function new();
            wr_pos       = 0;
            fill         = 0;
            spread_limit = bwm_pkg::RST_SPREAD_LIMIT;
            present_min  = bwm_pkg::RST_PRESENT_MIN;
            present_max  = bwm_pkg::RST_PRESENT_MAX;
            empty_mv     = bwm_pkg::RST_EMPTY;
            full_mv      = bwm_pkg::RST_FULL;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [12:0] val);
            case (idx)
                bwm_pkg::CFG_SPREAD_LIMIT: spread_limit = val[11:0];
                bwm_pkg::CFG_PRESENT_MIN:  present_min  = val;
                bwm_pkg::CFG_PRESENT_MAX:  present_max  = val;
                bwm_pkg::CFG_EMPTY:        empty_mv     = val;
                bwm_pkg::CFG_FULL:         full_mv      = val;
                default: ;
            endcase
        endfunction

        // Stores the new sample and works out the reading it produces.
        function void note_code(logic [11:0] code);
            int unsigned mv, lo, hi, sum, avg, batt, pct, spread;
            t_reading    r;
            mv = (32'(code) * 32'(bwm_pkg::PIN_FS_MV)) / CODE_FS;
            window[wr_pos] = mv[11:0];
            wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
            if (fill < WINDOW_DEPTH) begin
                fill++;
            end
            lo  = 32'hFFFF;
            hi  = 0;
            sum = 0;
            for (int k = 0; k < fill; k++) begin
                if (window[k] < lo) lo = window[k];
                if (window[k] > hi) hi = window[k];
                sum += window[k];
            end
            avg    = sum / fill;
            spread = hi - lo;
            batt   = (avg * 32'(bwm_pkg::BATT_NUM)) / 32'(bwm_pkg::BATT_DEN);
            if (batt <= 32'(empty_mv)) begin
                pct = 0;
            end else if (batt >= 32'(full_mv)) begin
                pct = 32'(bwm_pkg::PCT_FULL);
            end else begin
                pct = ((batt - 32'(empty_mv)) * 32'(bwm_pkg::PCT_FULL)) /
                      (32'(full_mv) - 32'(empty_mv));
            end
            r.avg_mv    = avg[11:0];
            r.batt_mv   = batt[12:0];
            r.pct       = pct[6:0];
            r.spread_mv = spread[11:0];
            r.present   = (fill >= WINDOW_DEPTH / 2) && (spread <= 32'(spread_limit)) &&
                          (batt >= 32'(present_min)) && (batt <= 32'(present_max));
            reading_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_reading(logic [47:0] data, logic user);
            t_reading w;
            if (reading_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected result: expected none, actual data %h user %b",
                             $time, data, user);
                end
                return;
            end
            w = reading_q.pop_front();
            compare_field("pin_avg_mv", w.avg_mv,    data[11:0]);
            compare_field("battery_mv", w.batt_mv,   data[24:12]);
            compare_field("percent",    w.pct,       data[31:25]);
            compare_field("spread_mv",  w.spread_mv, data[43:32]);
            compare_field("present",    w.present,   user);
        endfunction

        function int unsigned pending();
            return reading_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    battery_scoreboard board;
    int          hold_req;
    int          burst_left;
    int          cycle_cnt = 0;

    battery_window_monitor #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: checks each transfer and stalls on its own pattern. A new
    // hold request keeps tready low for a long stretch so the block backs up.
    initial begin
        int  run_left;
        bit  run_ready;
        int  hold_left;
        int  hold_seen;
        int  pick;
        run_left  = 0;
        run_ready = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                board.check_reading(m_axis_tdata, m_axis_tuser);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30) begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(20, 200);
                    end else if (pick < 70) begin
                        run_ready = $urandom_range(0, 1);
                        run_left  = $urandom_range(1, 4);
                    end else begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(1, 40);
                    end
                end
                run_left--;
                m_axis_tready <= run_ready;
            end
        end
    end

    // Offers one code and returns at the edge of its transfer with tvalid
    // still high; the caller either offers the next code or lowers tvalid.
    task automatic send_code(input logic [11:0] code);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, code};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_code(code);
    endtask

    task automatic send_item(input logic [11:0] code);
        int pick;
        int gap;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                gap = 0;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 10);
            end else begin
                gap = $urandom_range(20, 130);
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_code(code);
    endtask

    // Sender pause: nothing is offered until every reading owed has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    task automatic write_all(input logic [12:0] spread, input logic [12:0] pmin,
                             input logic [12:0] pmax, input logic [12:0] empty,
                             input logic [12:0] full);
        int extra;
        write_reg(bwm_pkg::CFG_SPREAD_LIMIT, spread);
        write_reg(bwm_pkg::CFG_PRESENT_MIN,  pmin);
        write_reg(bwm_pkg::CFG_PRESENT_MAX,  pmax);
        write_reg(bwm_pkg::CFG_EMPTY,        empty);
        write_reg(bwm_pkg::CFG_FULL,         full);
        // Writes to indexes past the last register must change nothing.
        extra = $urandom_range(0, 2);
        repeat (extra) begin
            write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      13'($urandom_range(0, 8191)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int kind);
        case (kind)
            0: write_all(13'(bwm_pkg::RST_SPREAD_LIMIT), bwm_pkg::RST_PRESENT_MIN,
                         bwm_pkg::RST_PRESENT_MAX, bwm_pkg::RST_EMPTY, bwm_pkg::RST_FULL);
            1: write_all(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
            2: write_all(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
            // Thresholds and plausible range both inverted.
            3: write_all(13'($urandom_range(0, 8191)), 13'd4300, 13'd2700,
                         13'd4200, 13'd3300);
            4: write_all(13'd4095, 13'd0, 13'h1FFF, 13'd0, 13'h1FFF);
            default: begin
                if ($urandom_range(0, 2) == 0) begin
                    write_all(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                              13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                              13'($urandom_range(0, 8191)));
                end else begin
                    write_all(13'($urandom_range(0, 1) ? $urandom_range(0, 300)
                                                       : $urandom_range(0, 4095)),
                              13'($urandom_range(2000, 3500)),
                              13'($urandom_range(3500, 5000)),
                              13'($urandom_range(2500, 4000)),
                              13'($urandom_range(3500, 5000)));
                end
            end
        endcase
    endtask

    function automatic logic [11:0] near_code(input int base, input int amp);
        int c;
        c = base + int'($urandom_range(0, 2 * amp)) - amp;
        if (c < 0) c = 0;
        if (c > 4095) c = 4095;
        return 12'(c);
    endfunction

    // Mostly steady runs that fill the window and can satisfy the presence
    // test, mixed with pure noise and steady runs broken by one spike.
    task automatic run_phase(input int n_items, input bit with_hold);
        int sent;
        int pick;
        int base;
        int amp;
        int len;
        int spike_at;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            base = $urandom_range(0, 1) ? $urandom_range(2300, 3900) : $urandom_range(0, 4095);
            case ($urandom_range(0, 2))
                0:       amp = 0;
                1:       amp = $urandom_range(1, 8);
                default: amp = $urandom_range(1, 200);
            endcase
            if (pick < 70) begin
                len = $urandom_range(16, 64);
                spike_at = -1;
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
                spike_at = -1;
            end else begin
                len = $urandom_range(8, 40);
                spike_at = $urandom_range(0, len - 1);
            end
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (with_hold && sent == 30) begin
                    hold_req++;
                end
                if ((pick >= 70 && pick < 85) || k == spike_at) begin
                    send_item(12'($urandom_range(0, 4095)));
                end else begin
                    send_item(near_code(base, amp));
                end
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        board      = new();
        hold_req   = 0;
        burst_left = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'd0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= bwm_pkg::CFG_SPREAD_LIMIT;
        i_cfg_data    <= 13'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a steady cell reaching half a window, then code extremes.
        repeat (16) send_code(12'd3000);
        send_code(12'd4095);
        send_code(12'd0);
        send_code(12'd1);
        send_code(12'd4094);
        send_code(12'd2048);
        send_code(12'd100);
        drain();
        // Directed: inverted thresholds and range, plus an unused index.
        write_reg(bwm_pkg::CFG_EMPTY,       13'd4200);
        write_reg(bwm_pkg::CFG_FULL,        13'd3300);
        write_reg(bwm_pkg::CFG_PRESENT_MIN, 13'd4300);
        write_reg(bwm_pkg::CFG_PRESENT_MAX, 13'd2700);
        write_reg(CFG_UNUSED_LO,            13'h1FFF);
        i_cfg_valid <= 1'b0;
        send_code(12'd3000);
        send_code(12'd4095);
        send_code(12'd2600);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(p);
            run_phase(PHASE_ITEMS, (p == 2) || (p == 7));
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
